FILE: src/wfpa_pkg.sv
// wfpa_pkg: shared types and codes for the worst-fit page allocator.
// No dependencies; imported by wfpa_ctrl, wfpa_dp and the top level.
package wfpa_pkg;

   localparam int SIZE_W  = 25;
   localparam int INDEX_W = 12;
   localparam int PAGES_W = 13;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_ALLOCATED    = 3'd0,
      ST_NO_FIT       = 3'd1,
      ST_ZERO_SIZE    = 3'd2,
      ST_FREED        = 3'd3,
      ST_FREE_IGNORED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RD_HOLD,
      RD_WALK,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_INIT_FIRST,
      WR_INIT_LAST,
      WR_ALLOC_FIRST,
      WR_ALLOC_LAST,
      WR_REM_FIRST,
      WR_REM_LAST,
      WR_FREE_FIRST,
      WR_FREE_LAST
   } wr_sel_type;

   typedef struct packed {
      logic       accept;
      logic       div_step;
      logic       walk_step;
      logic       prev_take;
      logic       next_take;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       load_rsp;
      status_type rsp_code;
   } cmd_type;

   typedef struct packed {
      logic size_zero;
      logic walk_end;
      logic found;
      logic hit;
      logic has_rem;
   } stat_type;

endpackage

FILE: src/wfpa_ram.sv
// wfpa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfpa_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/wfpa_ctrl.sv
// wfpa_ctrl: sequencer for tag init, page count, block walk, split and merge.
// Depends on wfpa_pkg; drives the wfpa_dp command struct.
module wfpa_ctrl import wfpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_func,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [16:0] {
      S_INIT_FIRST = 17'h00001,
      S_INIT_LAST  = 17'h00002,
      S_IDLE       = 17'h00004,
      S_DIV        = 17'h00008,
      S_AWALK      = 17'h00010,
      S_AWR0       = 17'h00020,
      S_AWR1       = 17'h00040,
      S_AWR2       = 17'h00080,
      S_AWR3       = 17'h00100,
      S_FSTART     = 17'h00200,
      S_FWALK      = 17'h00400,
      S_FRDP       = 17'h00800,
      S_FRDN       = 17'h01000,
      S_FCALC      = 17'h02000,
      S_FWR0       = 17'h04000,
      S_FWR1       = 17'h08000,
      S_RESP       = 17'h10000
   } state_type;

   state_type        state_ff, state_in;
   status_type       code_ff, code_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.rd_sel   = RD_HOLD;
      cmd.wr_sel   = WR_INIT_FIRST;
      cmd.rsp_code = code_ff;
      case (state_ff)
         S_INIT_FIRST: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_INIT_FIRST;
            state_in   = S_INIT_LAST;
         end
         S_INIT_LAST: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_INIT_LAST;
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_func == FUNC_FREE) ? S_FSTART : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.size_zero) begin
               code_in  = ST_ZERO_SIZE;
               state_in = S_RESP;
            end else begin
               state_in = S_AWALK;
            end
         end
         S_AWALK: begin
            cmd.walk_step = 1'b1;
            cmd.rd_sel    = RD_WALK;
            if (stat.walk_end) begin
               if (stat.found) begin
                  state_in = S_AWR0;
               end else begin
                  code_in  = ST_NO_FIT;
                  state_in = S_RESP;
               end
            end
         end
         S_AWR0: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ALLOC_FIRST;
            state_in   = S_AWR1;
         end
         S_AWR1: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ALLOC_LAST;
            code_in    = ST_ALLOCATED;
            state_in   = stat.has_rem ? S_AWR2 : S_RESP;
         end
         S_AWR2: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_REM_FIRST;
            state_in   = S_AWR3;
         end
         S_AWR3: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_REM_LAST;
            state_in   = S_RESP;
         end
         S_FSTART: begin
            state_in = S_FWALK;
         end
         S_FWALK: begin
            cmd.walk_step = 1'b1;
            cmd.rd_sel    = RD_WALK;
            if (stat.walk_end) begin
               if (stat.hit) begin
                  state_in = S_FRDP;
               end else begin
                  code_in  = ST_FREE_IGNORED;
                  state_in = S_RESP;
               end
            end
         end
         S_FRDP: begin
            cmd.rd_sel = RD_PREV;
            state_in   = S_FRDN;
         end
         S_FRDN: begin
            cmd.rd_sel    = RD_NEXT;
            cmd.prev_take = 1'b1;
            state_in      = S_FCALC;
         end
         S_FCALC: begin
            cmd.next_take = 1'b1;
            state_in      = S_FWR0;
         end
         S_FWR0: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_FREE_FIRST;
            state_in   = S_FWR1;
         end
         S_FWR1: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_FREE_LAST;
            code_in    = ST_FREED;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_FIRST;
         code_ff      <= ST_ALLOCATED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/wfpa_dp.sv
// wfpa_dp: page count, block walk, split/merge arithmetic and result register.
// Depends on wfpa_pkg; driven by wfpa_ctrl, talks to the tag RAM.
module wfpa_dp import wfpa_pkg::*; #(
   parameter int HEAP_PAGE_COUNT = 4096,
   parameter int PAGE_BYTES      = 4096,
   localparam int AW = $clog2(HEAP_PAGE_COUNT),
   localparam int PW = $clog2(HEAP_PAGE_COUNT + 1),
   localparam int TW = PW + 1
) (
   input  logic               clock,
   input  logic               req_func,
   input  logic [SIZE_W-1:0]  req_size_bytes,
   input  logic [INDEX_W-1:0] req_page_index,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic               ram_wr_en,
   output logic [AW-1:0]      ram_wr_addr,
   output logic [TW-1:0]      ram_wr_data,
   output logic [AW-1:0]      ram_rd_addr,
   input  logic [TW-1:0]      ram_rd_data,
   output status_type         rsp_status,
   output logic [INDEX_W-1:0] rsp_block_index,
   output logic [PAGES_W-1:0] rsp_block_pages
);

   localparam int CW     = (PW > PAGES_W) ? PW : PAGES_W;
   localparam int CMPW   = (PW > SIZE_W) ? PW : SIZE_W;
   localparam int NUM_W  = SIZE_W + 1;
   localparam int RCP_SH = NUM_W + $clog2(PAGE_BYTES);
   localparam int RCP_W  = NUM_W + 2;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam logic [63:0] RCP_FULL =
      ((64'd1 << RCP_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
   localparam logic [RCP_W-1:0] RCP      = RCP_W'(RCP_FULL);
   localparam logic [NUM_W-1:0] ROUND_UP = NUM_W'(PAGE_BYTES - 1);
   localparam logic [PW-1:0]    HEAP_N   = PW'(HEAP_PAGE_COUNT);

   // block length from a tag: zero counts as one page, clipped to lim
   function automatic logic [PW-1:0] clip_mag(input logic [TW-1:0] t,
                                               input logic [PW-1:0] lim);
      logic [TW-1:0] mag;
      mag = t[TW-1] ? (~t + TW'(1)) : t;
      if (mag == '0) begin
         mag = TW'(1);
      end
      if (mag > {1'b0, lim}) begin
         return lim;
      end
      return mag[PW-1:0];
   endfunction

   function automatic logic [TW-1:0] neg_tag(input logic [PW-1:0] x);
      return (~{1'b0, x}) + TW'(1);
   endfunction

   logic               func_ff;
   logic               size_zero_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [SIZE_W-1:0]  pages_ff;
   logic [PW-1:0]      pos_ff;
   logic [PW-1:0]      len_ff;
   logic               found_ff;
   logic [PW-1:0]      blk_pos_ff;
   logic [PW-1:0]      blk_len_ff;
   status_type         rsp_status_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [PAGES_W-1:0] rsp_pages_ff;

   logic [PROD_W-1:0] prod, prod_sh;
   logic [PW-1:0]     pages_w;
   logic              is_free, is_alloc;
   logic [PW-1:0]     room, len_w, pos_next;
   logic              fits, cand, at_idx;
   logic [PW-1:0]     prev_n, prev_first, prev_total;
   logic [PW-1:0]     after, next_n, next_total;
   logic [PW-1:0]     rd_pos, wr_pos;
   logic [CW-1:0]     out_index, out_pages;

   // pages = (size + PAGE_BYTES - 1) * RCP >> RCP_SH, exact over the whole range
   assign prod    = PROD_W'(num_ff) * PROD_W'(RCP);
   assign prod_sh = prod >> RCP_SH;
   assign pages_w = pages_ff[PW-1:0];

   assign is_free  = ram_rd_data[TW-1];
   assign is_alloc = !ram_rd_data[TW-1] && (ram_rd_data != '0);
   assign room     = HEAP_N - pos_ff;
   assign len_w    = clip_mag(ram_rd_data, room);
   assign pos_next = pos_ff + len_w;
   assign fits     = (CMPW'(len_w) >= CMPW'(pages_ff));
   assign cand     = is_free && fits && (!found_ff || (len_w > blk_len_ff));
   assign at_idx   = (CW'(pos_ff) == CW'(idx_ff));

   assign prev_n     = clip_mag(ram_rd_data, pos_ff);
   assign after      = pos_ff + len_ff;
   assign next_n     = clip_mag(ram_rd_data, HEAP_N - after);

   always_comb begin
      if ((pos_ff != '0) && is_free) begin
         prev_first = pos_ff - prev_n;
         prev_total = len_ff + prev_n;
      end else begin
         prev_first = pos_ff;
         prev_total = len_ff;
      end
      if ((after != HEAP_N) && is_free) begin
         next_total = blk_len_ff + next_n;
      end else begin
         next_total = blk_len_ff;
      end
   end

   always_comb begin
      stat.size_zero = size_zero_ff;
      stat.found     = found_ff || cand;
      stat.hit       = at_idx && is_alloc;
      stat.has_rem   = (blk_len_ff > pages_w);
      if (func_ff == FUNC_FREE) begin
         stat.walk_end = at_idx || (pos_next == HEAP_N) || (CW'(pos_next) > CW'(idx_ff));
      end else begin
         stat.walk_end = (pos_next == HEAP_N);
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_HOLD: rd_pos = pos_ff;
         RD_WALK: rd_pos = pos_next;
         RD_PREV: rd_pos = pos_ff - PW'(1);
         RD_NEXT: rd_pos = after;
         default: rd_pos = pos_ff;
      endcase
   end
   assign ram_rd_addr = rd_pos[AW-1:0];

   always_comb begin
      case (cmd.wr_sel)
         WR_INIT_FIRST: begin
            wr_pos      = '0;
            ram_wr_data = neg_tag(HEAP_N);
         end
         WR_INIT_LAST: begin
            wr_pos      = HEAP_N - PW'(1);
            ram_wr_data = neg_tag(HEAP_N);
         end
         WR_ALLOC_FIRST: begin
            wr_pos      = blk_pos_ff;
            ram_wr_data = {1'b0, pages_w};
         end
         WR_ALLOC_LAST: begin
            wr_pos      = blk_pos_ff + pages_w - PW'(1);
            ram_wr_data = {1'b0, pages_w};
         end
         WR_REM_FIRST: begin
            wr_pos      = blk_pos_ff + pages_w;
            ram_wr_data = neg_tag(blk_len_ff - pages_w);
         end
         WR_REM_LAST: begin
            wr_pos      = blk_pos_ff + blk_len_ff - PW'(1);
            ram_wr_data = neg_tag(blk_len_ff - pages_w);
         end
         WR_FREE_FIRST: begin
            wr_pos      = blk_pos_ff;
            ram_wr_data = neg_tag(blk_len_ff);
         end
         WR_FREE_LAST: begin
            wr_pos      = blk_pos_ff + blk_len_ff - PW'(1);
            ram_wr_data = neg_tag(blk_len_ff);
         end
         default: begin
            wr_pos      = '0;
            ram_wr_data = neg_tag(HEAP_N);
         end
      endcase
   end
   assign ram_wr_en   = cmd.wr_en;
   assign ram_wr_addr = wr_pos[AW-1:0];

   always_comb begin
      case (cmd.rsp_code)
         ST_ALLOCATED: begin
            out_index = CW'(blk_pos_ff);
            out_pages = CW'(pages_ff);
         end
         ST_FREED: begin
            out_index = CW'(pos_ff);
            out_pages = CW'(len_ff);
         end
         default: begin
            out_index = '0;
            out_pages = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff      <= req_func;
         size_zero_ff <= (req_size_bytes == '0);
         idx_ff       <= req_page_index;
         num_ff       <= NUM_W'(req_size_bytes) + ROUND_UP;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
      end
      if (cmd.div_step) begin
         pages_ff <= prod_sh[SIZE_W-1:0];
      end
      if (cmd.walk_step) begin
         if (func_ff == FUNC_FREE) begin
            if (at_idx) begin
               len_ff <= len_w;
            end else begin
               pos_ff <= pos_next;
            end
         end else begin
            pos_ff <= pos_next;
            if (cand) begin
               found_ff   <= 1'b1;
               blk_pos_ff <= pos_ff;
               blk_len_ff <= len_w;
            end
         end
      end
      if (cmd.prev_take) begin
         blk_pos_ff <= prev_first;
         blk_len_ff <= prev_total;
      end
      if (cmd.next_take) begin
         blk_len_ff <= next_total;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_index_ff  <= out_index[INDEX_W-1:0];
         rsp_pages_ff  <= out_pages[PAGES_W-1:0];
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_block_pages = rsp_pages_ff;

endmodule

FILE: src/worst_fit_page_allocator.sv
// worst_fit_page_allocator: top level of the boundary-tag worst-fit page allocator.
// Depends on wfpa_pkg, wfpa_ram, wfpa_ctrl and wfpa_dp.
//
// Heap of HEAP_PAGE_COUNT pages kept as a chain of blocks, each tagged at its
// first and last page in a tag RAM with one read and one write port. One
// request is handled at a time and always yields one response beat. Allocate:
// the byte size is turned into pages, then the chain is walked block by block,
// then 2 or 4 tag writes are made and the result is posted. A zero size posts
// after the page count and a failed fit after the walk. Free: a start state,
// then a walk block by block up to the target page, then both neighbors are
// read and the merged tags written before the result is posted; an ignored
// free posts right after the walk. The walk rate is set by the tag RAM's
// single read port. After reset the block stalls while it tags the whole heap
// as one free block. A response waiting on rsp_stall does not keep the next
// request out, but that request's response waits until it drains.
module worst_fit_page_allocator import wfpa_pkg::*; #(
   parameter int HEAP_PAGE_COUNT = 4096,
   parameter int PAGE_BYTES      = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [SIZE_W-1:0]  req_size_bytes,
   input  logic [INDEX_W-1:0] req_page_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [INDEX_W-1:0] rsp_block_index,
   output logic [PAGES_W-1:0] rsp_block_pages
);

   localparam int AW = $clog2(HEAP_PAGE_COUNT);
   localparam int PW = $clog2(HEAP_PAGE_COUNT + 1);
   localparam int TW = PW + 1;

   cmd_type       cmd;
   stat_type      stat;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [TW-1:0] ram_wr_data, ram_rd_data;
   status_type    rsp_status_dp;

   wfpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wfpa_dp #(
      .HEAP_PAGE_COUNT (HEAP_PAGE_COUNT),
      .PAGE_BYTES      (PAGE_BYTES)
   ) u_dp (
      .clock           (clock),
      .req_func        (req_func),
      .req_size_bytes  (req_size_bytes),
      .req_page_index  (req_page_index),
      .cmd             (cmd),
      .stat            (stat),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_status      (rsp_status_dp),
      .rsp_block_index (rsp_block_index),
      .rsp_block_pages (rsp_block_pages)
   );

   wfpa_ram #(
      .WIDTH (TW),
      .DEPTH (HEAP_PAGE_COUNT)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_status = rsp_status_dp;

   // tag init runs right after reset
   a_init_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during tag init");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request port open right after accept");

   // failed requests report no block
   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NO_FIT || rsp_status == ST_ZERO_SIZE ||
                    rsp_status == ST_FREE_IGNORED)
      |-> rsp_block_index == '0 && rsp_block_pages == '0)
      else $error("failed request reports a block");

endmodule

FILE: test/worst_fit_page_allocator_checker.sv
// worst_fit_page_allocator_checker: watches both channels of the page allocator,
// predicts each reply from its own copy of the boundary-tag heap and compares.
// Depends on wfpa_pkg; instantiated next to the block by worst_fit_page_allocator_tb.
module worst_fit_page_allocator_checker import wfpa_pkg::*; #(
   parameter int PAGE_COUNT = 4096,
   parameter int PAGE_BYTES = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_func,
   input  logic [SIZE_W-1:0]  req_size_bytes,
   input  logic [INDEX_W-1:0] req_page_index,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_status,
   input  logic [INDEX_W-1:0] rsp_block_index,
   input  logic [PAGES_W-1:0] rsp_block_pages,
   output int unsigned        mismatch_count,
   output int unsigned        replies_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] index;
      logic [PAGES_W-1:0] pages;
   } heap_reply_type;

   int             page_tag [PAGE_COUNT];
   heap_reply_type owed_replies [$];

   function automatic void clear_heap();
      for (int i = 0; i < PAGE_COUNT; i++) page_tag[i] = 0;
      page_tag[0] = -PAGE_COUNT;
      page_tag[PAGE_COUNT-1] = -PAGE_COUNT;
   endfunction

   // zero tag walks as one page; spans are clipped at the heap end
   function automatic int unsigned block_span(int unsigned pos);
      int unsigned len;
      if (page_tag[pos] > 0) len = page_tag[pos];
      else if (page_tag[pos] < 0) len = -page_tag[pos];
      else len = 1;
      if (len > PAGE_COUNT - pos) len = PAGE_COUNT - pos;
      return len;
   endfunction

   function automatic void set_tags(int unsigned first, int unsigned pages, int value);
      page_tag[first] = value;
      page_tag[first + pages - 1] = value;
   endfunction

   function automatic heap_reply_type carve_block(logic [SIZE_W-1:0] bytes);
      heap_reply_type reply;
      int unsigned    want, pos, len, best_pos, best_len;
      bit             found;
      reply.status = ST_ZERO_SIZE;
      reply.index  = '0;
      reply.pages  = '0;
      if (bytes == 0) return reply;
      want = (bytes + PAGE_BYTES - 1) / PAGE_BYTES;
      pos = 0;
      best_pos = 0;
      best_len = 0;
      found = 1'b0;
      while (pos < PAGE_COUNT) begin
         len = block_span(pos);
         if (page_tag[pos] < 0 && len >= want && (!found || len > best_len)) begin
            found = 1'b1;
            best_len = len;
            best_pos = pos;
         end
         pos += len;
      end
      if (!found) begin
         reply.status = ST_NO_FIT;
         return reply;
      end
      set_tags(best_pos, want, int'(want));
      if (best_len > want) set_tags(best_pos + want, best_len - want, -int'(best_len - want));
      reply.status = ST_ALLOCATED;
      reply.index  = INDEX_W'(best_pos);
      reply.pages  = PAGES_W'(want);
      return reply;
   endfunction

   function automatic heap_reply_type release_block(int unsigned idx);
      heap_reply_type reply;
      int unsigned    pos, len, first, total, run, after;
      bit             hit;
      reply.status = ST_FREE_IGNORED;
      reply.index  = '0;
      reply.pages  = '0;
      pos = 0;
      len = 0;
      hit = 1'b0;
      while (pos < PAGE_COUNT && pos <= idx) begin
         len = block_span(pos);
         if (pos == idx) begin
            hit = page_tag[pos] > 0;
            break;
         end
         pos += len;
      end
      if (!hit) return reply;
      first = idx;
      total = len;
      set_tags(idx, len, 0);
      if (idx > 0 && page_tag[idx-1] < 0) begin
         run = -page_tag[idx-1];
         if (run > idx) run = idx;
         first = idx - run;
         total += run;
      end
      after = idx + len;
      if (after < PAGE_COUNT && page_tag[after] < 0) begin
         run = -page_tag[after];
         if (run > PAGE_COUNT - after) run = PAGE_COUNT - after;
         total += run;
      end
      set_tags(first, total, -int'(total));
      reply.status = ST_FREED;
      reply.index  = INDEX_W'(idx);
      reply.pages  = PAGES_W'(len);
      return reply;
   endfunction

   task automatic report_mismatch(string note);
      $display("%0t ns: reply mismatch: %s", $time, note);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      heap_reply_type owed;
      if (reset) begin
         clear_heap();
         owed_replies.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_ALLOC) owed_replies.push_back(carve_block(req_size_bytes));
            else owed_replies.push_back(release_block(req_page_index));
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_replies.size() == 0) begin
               report_mismatch($sformatf("beat with nothing owed, status %0d", rsp_status));
            end else begin
               owed = owed_replies.pop_front();
               if (rsp_status !== owed.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, owed.status));
               if (rsp_block_index !== owed.index)
                  report_mismatch($sformatf("block_index %0d, expected %0d",
                                            rsp_block_index, owed.index));
               if (rsp_block_pages !== owed.pages)
                  report_mismatch($sformatf("block_pages %0d, expected %0d",
                                            rsp_block_pages, owed.pages));
            end
         end
      end
      replies_owed = owed_replies.size();
   end

endmodule

FILE: test/worst_fit_page_allocator_tb.sv
// worst_fit_page_allocator_tb: clock, reset, request and stall stimulus for the
// page allocator; verdict from the failure count of worst_fit_page_allocator_checker.
// Depends on wfpa_pkg, worst_fit_page_allocator and worst_fit_page_allocator_checker.
module worst_fit_page_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wfpa_pkg::*;

   localparam int PAGE_COUNT  = 4096;
   localparam int PAGE_BYTES  = 4096;
   localparam int QUIET_LIMIT = 20000;
   localparam int PHASE_ITEMS = 170;
   localparam int HOLDOFF     = 400;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_func       = FUNC_ALLOC;
   logic [SIZE_W-1:0]  req_size_bytes = '0;
   logic [INDEX_W-1:0] req_page_index = '0;
   logic               rsp_stall      = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [INDEX_W-1:0] rsp_block_index;
   logic [PAGES_W-1:0] rsp_block_pages;

   int unsigned        mismatch_count;
   int unsigned        replies_owed;
   int unsigned        send_idle_pct = 0;
   int unsigned        stall_pct     = 0;
   int unsigned        holdoff_ask   = 0;
   int unsigned        holdoff_left  = 0;
   int unsigned        quiet_cycles  = 0;
   int unsigned        idle_plan  [4] = '{0, 83, 0, 12};
   int unsigned        stall_plan [4] = '{0, 0, 83, 12};
   logic [INDEX_W-1:0] live_blocks [$];

   worst_fit_page_allocator #(
      .HEAP_PAGE_COUNT(PAGE_COUNT),
      .PAGE_BYTES     (PAGE_BYTES)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_size_bytes (req_size_bytes),
      .req_page_index (req_page_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_block_index(rsp_block_index),
      .rsp_block_pages(rsp_block_pages)
   );

   worst_fit_page_allocator_checker #(
      .PAGE_COUNT(PAGE_COUNT),
      .PAGE_BYTES(PAGE_BYTES)
   ) reply_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_size_bytes (req_size_bytes),
      .req_page_index (req_page_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_block_index(rsp_block_index),
      .rsp_block_pages(rsp_block_pages),
      .mismatch_count (mismatch_count),
      .replies_owed   (replies_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (holdoff_ask != 0) begin
         holdoff_left = holdoff_ask;
         holdoff_ask = 0;
      end
      if (holdoff_left != 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // blocks granted so far, candidates for well-formed frees
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_ALLOCATED)
         live_blocks.push_back(rsp_block_index);
   end

   task automatic offer_request(input logic func, input logic [SIZE_W-1:0] bytes,
                                input logic [INDEX_W-1:0] page);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_size_bytes <= bytes;
      req_page_index <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_random_request();
      int unsigned        roll, pick, pages;
      logic [INDEX_W-1:0] page;
      roll = $urandom_range(99);
      if (roll < 55) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            offer_request(FUNC_ALLOC, '0, INDEX_W'($urandom));
         end else if (roll < 13) begin
            offer_request(FUNC_ALLOC, SIZE_W'($urandom_range(16777216)), INDEX_W'($urandom));
         end else begin
            pages = (roll < 23) ? $urandom_range(600, 17) : $urandom_range(16, 1);
            offer_request(FUNC_ALLOC,
                          SIZE_W'((pages - 1) * PAGE_BYTES + $urandom_range(PAGE_BYTES, 1)),
                          INDEX_W'($urandom));
         end
      end else if (live_blocks.size() != 0 && $urandom_range(99) < 85) begin
         pick = $urandom_range(live_blocks.size() - 1);
         page = live_blocks[pick];
         live_blocks.delete(pick);
         offer_request(FUNC_FREE, SIZE_W'($urandom), page);
      end else begin
         offer_request(FUNC_FREE, SIZE_W'($urandom), INDEX_W'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (replies_owed != 0) @(negedge clock);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      offer_request(FUNC_ALLOC, 0, '0);          // zero size
      offer_request(FUNC_ALLOC, 16777216, '0);   // whole heap
      offer_request(FUNC_ALLOC, 1, '0);          // heap full
      offer_request(FUNC_FREE, '0, 4095);        // inside a block
      offer_request(FUNC_FREE, '0, 0);
      offer_request(FUNC_FREE, '0, 0);           // start of a free block
      offer_request(FUNC_ALLOC, 4096, '0);
      offer_request(FUNC_ALLOC, 1, '0);
      offer_request(FUNC_ALLOC, 4096, '0);
      offer_request(FUNC_ALLOC, 16764928, '0);   // exact fit, no remainder
      offer_request(FUNC_ALLOC, 4097, '0);
      offer_request(FUNC_FREE, '0, 0);
      offer_request(FUNC_FREE, '0, 2);
      offer_request(FUNC_ALLOC, 2, '0);          // tie, first block wins
      offer_request(FUNC_FREE, '0, 1);           // merge with next
      offer_request(FUNC_FREE, '0, 0);
      offer_request(FUNC_FREE, '0, 3);           // merge with previous
      offer_request(FUNC_ALLOC, 4097, '0);
      offer_request(FUNC_ALLOC, 1, '0);
      offer_request(FUNC_ALLOC, 8191, '0);
      offer_request(FUNC_FREE, '0, 0);
      offer_request(FUNC_FREE, '0, 3);
      offer_request(FUNC_FREE, '0, 2);           // merge on both sides
      offer_request(FUNC_ALLOC, 16777215, '0);
      offer_request(FUNC_FREE, '0, 0);
      req_valid <= 1'b0;
      wait_drained();
      live_blocks.delete();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         stall_pct     = stall_plan[phase];
         if (phase == 0) holdoff_ask = HOLDOFF;
         repeat (PHASE_ITEMS) offer_random_request();
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (200) @(negedge clock);
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: worst_fit_page_allocator.f
src/wfpa_pkg.sv
src/wfpa_ram.sv
src/wfpa_ctrl.sv
src/wfpa_dp.sv
src/worst_fit_page_allocator.sv
test/worst_fit_page_allocator_checker.sv
test/worst_fit_page_allocator_tb.sv
